// ----- design/multi_stop_color_gradient_defines.svh -----
// assertion macros shared by the gradient rtl
// no dependencies; included by the files that carry assertions
`ifndef MULTI_STOP_COLOR_GRADIENT_DEFINES_SVH
`define MULTI_STOP_COLOR_GRADIENT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define MSCG_ASSERT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("gradient assertion failed");

// next-cycle implication, disabled during reset
`define MSCG_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("gradient assertion failed");

`else

`define MSCG_ASSERT(label, ck, rn, ante, cons)
`define MSCG_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

// ----- design/mscg_pkg.sv -----
// types, constants and codes of the multi-stop color gradient
// no dependencies; used by mscg_div and the top level
package mscg_pkg;

    localparam int MAX_PIVOTS  = 16;
    localparam int MAX_ENTRIES = 256;

    localparam int COMP_W    = 16;
    localparam int NUM_COMP  = 3;
    localparam int RGB_W     = COMP_W * NUM_COMP;
    localparam int IDX_W     = 8;
    localparam int SLOT_W    = 4;
    localparam int PCNT_W    = 5;
    localparam int CCNT_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 9;

    // divider: product of a component delta and an entry position over a span
    localparam int DIV_W      = COMP_W + IDX_W;
    localparam int DEN_W      = CCNT_W;
    localparam int STEP_W     = $clog2(DIV_W + 1);
    localparam int SPAN_STEPS = CCNT_W;
    localparam int SEG_STEPS  = IDX_W;
    localparam int BLEND_STEPS = DIV_W;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 1'd1;

    localparam logic [PCNT_W-1:0] PIVOT_COUNT_RST = 5'd2;
    localparam logic [CCNT_W-1:0] COLOR_COUNT_RST = 9'd256;

    typedef logic [COMP_W-1:0] comp_t;

    // index 2 red, 1 green, 0 blue
    typedef comp_t [NUM_COMP-1:0] rgb_t;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] pivot_slot;
        logic [IDX_W-1:0]  entry_index;
        logic [COMP_W-1:0] pivot_red;
        logic [COMP_W-1:0] pivot_green;
        logic [COMP_W-1:0] pivot_blue;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  out_index;
        logic [COMP_W-1:0] out_red;
        logic [COMP_W-1:0] out_green;
        logic [COMP_W-1:0] out_blue;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
    } div_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAN,
        ST_SEG,
        ST_RDA,
        ST_RDB,
        ST_MUL,
        ST_DIV,
        ST_OUT,
        ST_LAST
    } state_t;

endpackage

// ----- design/mscg_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
module mscg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/mscg_div.sv -----
// restoring divider, one quotient bit per cycle, variable step count
// depends on mscg_pkg; the caller aligns the dividend to the top bits
module mscg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  mscg_pkg::div_req_t req,
    output mscg_pkg::div_res_t res
);

    logic [mscg_pkg::DEN_W-1:0]  rem_reg;
    logic [mscg_pkg::DIV_W-1:0]  quo_reg;
    logic [mscg_pkg::DEN_W-1:0]  den_reg;
    logic [mscg_pkg::STEP_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [mscg_pkg::DEN_W:0]   rem_sh;
    logic [mscg_pkg::DEN_W:0]   rem_sub;
    logic                       fits;
    logic [mscg_pkg::DEN_W-1:0] rem_next;
    logic [mscg_pkg::DIV_W-1:0] quo_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[mscg_pkg::DIV_W-1]};
        rem_sub  = rem_sh - {1'b0, den_reg};
        fits     = (rem_sh >= {1'b0, den_reg});
        rem_next = fits ? rem_sub[mscg_pkg::DEN_W-1:0] : rem_sh[mscg_pkg::DEN_W-1:0];
        quo_next = {quo_reg[mscg_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != mscg_pkg::STEP_W'(1));
            done_reg <= (cnt_reg == mscg_pkg::STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

// ----- design/multi_stop_color_gradient.sv -----
// multi-stop linear color gradient palette, top level
// depends on mscg_pkg, mscg_ram, mscg_div and multi_stop_color_gradient_defines.svh
//
// usage:
//   in channel (in_valid/in_ready/in_item) carries pivot writes and lookups.
//   a write stores one 48-bit rgb pivot into a 16-entry pivot memory;
//   it produces no output transaction.
//   a lookup returns one out transaction (out_valid/out_ready/out_item) with
//   the interpolated color of the named palette entry.
//   a new transaction is taken in the cycle after the result is loaded.
//   the pace is set by the restoring dividers: lane 0 does the span
//   (9 quotient bits) and then segment and position (8), and the three
//   component blends (24 quotient bits each) run in three divider lanes
//   side by side. lookups that fall on the last pivot skip the blend.
//   configuration (cfg_we/cfg_index/cfg_data) sets pivot_count and
//   color_count; it must be written only while no lookup is in flight;
//   the block itself does not enforce this.
//   reset clears the control state and sets pivot_count to 2 and color_count
//   to 256; pivot memory contents are unknown until written.
//   a stalled receiver holds the result in the output register; the block
//   still takes pivot writes and one more lookup, which then waits in its
//   last state with in_ready low until the register drains.
module multi_stop_color_gradient (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mscg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mscg_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mscg_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mscg_pkg::out_item_t                 out_item
);

    `include "multi_stop_color_gradient_defines.svh"

    mscg_pkg::state_t state_reg;
    mscg_pkg::state_t state_next;

    logic [mscg_pkg::PCNT_W-1:0] pivot_count_reg;
    logic [mscg_pkg::CCNT_W-1:0] color_count_reg;

    logic [mscg_pkg::IDX_W-1:0]  k_reg;
    logic [mscg_pkg::SLOT_W-1:0] plast_reg;
    logic [mscg_pkg::DEN_W-1:0]  den_reg;
    logic [mscg_pkg::SLOT_W-1:0] seg_reg;
    logic [mscg_pkg::IDX_W-1:0]  pos_reg;
    mscg_pkg::rgb_t              a_reg;
    mscg_pkg::rgb_t              mag_reg;
    logic [mscg_pkg::NUM_COMP-1:0] neg_reg;

    logic                out_valid_reg;
    mscg_pkg::out_item_t out_item_reg;
    mscg_pkg::out_item_t out_item_next;
    logic                out_load;
    logic                out_free;

    logic in_accept;
    logic lookup_accept;
    logic write_accept;

    logic [mscg_pkg::PCNT_W-1:0] p_sat;
    logic [mscg_pkg::PCNT_W-1:0] p_last;
    logic [mscg_pkg::CCNT_W-1:0] c_sat;
    logic [mscg_pkg::CCNT_W:0]   span_sum;
    logic [mscg_pkg::CCNT_W-1:0] span_num;
    logic                        single;
    logic [mscg_pkg::CCNT_W-1:0] span;
    logic                        span_lt2;
    logic [mscg_pkg::IDX_W-1:0]  seg_q;
    logic                        seg_past;

    logic                        ram_we;
    logic                        ram_re;
    logic [mscg_pkg::SLOT_W-1:0] ram_rd_addr;
    mscg_pkg::rgb_t              ram_wr_data;
    mscg_pkg::rgb_t              ram_rd_data;

    mscg_pkg::div_req_t div_req [mscg_pkg::NUM_COMP];
    mscg_pkg::div_res_t div_res [mscg_pkg::NUM_COMP];

    mscg_pkg::rgb_t blend;

    // ---- configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_count_reg <= mscg_pkg::PIVOT_COUNT_RST;
            color_count_reg <= mscg_pkg::COLOR_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mscg_pkg::REG_PIVOT_COUNT: pivot_count_reg <= cfg_data[mscg_pkg::PCNT_W-1:0];
                mscg_pkg::REG_COLOR_COUNT: color_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- effective counts and span numerator
    always_comb
    begin
        if (pivot_count_reg == '0)
        begin
            p_sat = mscg_pkg::PCNT_W'(1);
        end
        else if (pivot_count_reg > mscg_pkg::PCNT_W'(mscg_pkg::MAX_PIVOTS))
        begin
            p_sat = mscg_pkg::PCNT_W'(mscg_pkg::MAX_PIVOTS);
        end
        else
        begin
            p_sat = pivot_count_reg;
        end
        if (color_count_reg > mscg_pkg::CCNT_W'(mscg_pkg::MAX_ENTRIES))
        begin
            c_sat = mscg_pkg::CCNT_W'(mscg_pkg::MAX_ENTRIES);
        end
        else
        begin
            c_sat = color_count_reg;
        end
        p_last   = p_sat - 1'b1;
        single   = (p_sat == mscg_pkg::PCNT_W'(1));
        span_sum = {1'b0, c_sat} + {{(mscg_pkg::CCNT_W + 1 - mscg_pkg::PCNT_W){1'b0}}, p_last}
                   - (mscg_pkg::CCNT_W + 1)'(1);
        span_num = span_sum[mscg_pkg::CCNT_W-1:0];
        span     = div_res[0].quotient[mscg_pkg::CCNT_W-1:0];
        span_lt2 = (span < mscg_pkg::CCNT_W'(2));
        seg_q    = div_res[0].quotient[mscg_pkg::IDX_W-1:0];
        seg_past = (seg_q >= mscg_pkg::IDX_W'(plast_reg));
    end

    // ---- handshake
    assign in_ready      = (state_reg == mscg_pkg::ST_IDLE);
    assign in_accept     = in_valid && in_ready;
    assign lookup_accept = in_accept && (in_item.command == mscg_pkg::CMD_LOOKUP);
    assign write_accept  = in_accept && (in_item.command == mscg_pkg::CMD_WRITE);
    assign out_free      = !out_valid_reg || out_ready;

    // ---- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mscg_pkg::ST_IDLE:
            begin
                if (lookup_accept)
                begin
                    state_next = single ? mscg_pkg::ST_LAST : mscg_pkg::ST_SPAN;
                end
            end
            mscg_pkg::ST_SPAN:
            begin
                if (div_res[0].done)
                begin
                    state_next = span_lt2 ? mscg_pkg::ST_LAST : mscg_pkg::ST_SEG;
                end
            end
            mscg_pkg::ST_SEG:
            begin
                if (div_res[0].done)
                begin
                    state_next = seg_past ? mscg_pkg::ST_LAST : mscg_pkg::ST_RDA;
                end
            end
            mscg_pkg::ST_RDA: state_next = mscg_pkg::ST_RDB;
            mscg_pkg::ST_RDB: state_next = mscg_pkg::ST_MUL;
            mscg_pkg::ST_MUL: state_next = mscg_pkg::ST_DIV;
            mscg_pkg::ST_DIV:
            begin
                if (div_res[0].done)
                begin
                    state_next = mscg_pkg::ST_OUT;
                end
            end
            mscg_pkg::ST_OUT,
            mscg_pkg::ST_LAST:
            begin
                if (out_free)
                begin
                    state_next = mscg_pkg::ST_IDLE;
                end
            end
            default: state_next = mscg_pkg::ST_IDLE;
        endcase
    end

    // ---- blend: from + or - the truncated quotient
    always_comb
    begin
        for (int i = 0; i < mscg_pkg::NUM_COMP; i++)
        begin
            if (neg_reg[i])
            begin
                blend[i] = a_reg[i] - div_res[i].quotient[mscg_pkg::COMP_W-1:0];
            end
            else
            begin
                blend[i] = a_reg[i] + div_res[i].quotient[mscg_pkg::COMP_W-1:0];
            end
        end
    end

    // ---- outputs of the sequencer
    always_comb
    begin
        ram_we      = write_accept;
        ram_wr_data = {in_item.pivot_red, in_item.pivot_green, in_item.pivot_blue};
        ram_re      = 1'b0;
        ram_rd_addr = plast_reg;
        out_load    = 1'b0;
        out_item_next.out_index = k_reg;
        out_item_next.out_red   = ram_rd_data[2];
        out_item_next.out_green = ram_rd_data[1];
        out_item_next.out_blue  = ram_rd_data[0];
        for (int i = 0; i < mscg_pkg::NUM_COMP; i++)
        begin
            div_req[i].start    = 1'b0;
            div_req[i].steps    = mscg_pkg::STEP_W'(mscg_pkg::BLEND_STEPS);
            div_req[i].dividend = mscg_pkg::DIV_W'(mag_reg[i]) * mscg_pkg::DIV_W'(pos_reg);
            div_req[i].divisor  = den_reg;
        end
        case (state_reg)
            mscg_pkg::ST_IDLE:
            begin
                if (lookup_accept && single)
                begin
                    ram_re      = 1'b1;
                    ram_rd_addr = '0;
                end
                div_req[0].start    = lookup_accept && !single;
                div_req[0].steps    = mscg_pkg::STEP_W'(mscg_pkg::SPAN_STEPS);
                div_req[0].dividend = {span_num,
                                       {(mscg_pkg::DIV_W - mscg_pkg::CCNT_W){1'b0}}};
                div_req[0].divisor  = mscg_pkg::DEN_W'(p_last);
            end
            mscg_pkg::ST_SPAN:
            begin
                ram_re              = div_res[0].done && span_lt2;
                div_req[0].start    = div_res[0].done && !span_lt2;
                div_req[0].steps    = mscg_pkg::STEP_W'(mscg_pkg::SEG_STEPS);
                div_req[0].dividend = {k_reg, {(mscg_pkg::DIV_W - mscg_pkg::IDX_W){1'b0}}};
                div_req[0].divisor  = span - 1'b1;
            end
            mscg_pkg::ST_SEG:
            begin
                ram_re = div_res[0].done;
                if (!seg_past)
                begin
                    ram_rd_addr = seg_q[mscg_pkg::SLOT_W-1:0];
                end
            end
            mscg_pkg::ST_RDA:
            begin
                ram_re      = 1'b1;
                ram_rd_addr = seg_reg + 1'b1;
            end
            mscg_pkg::ST_MUL:
            begin
                for (int i = 0; i < mscg_pkg::NUM_COMP; i++)
                begin
                    div_req[i].start = 1'b1;
                end
            end
            mscg_pkg::ST_OUT:
            begin
                out_load                = out_free;
                out_item_next.out_red   = blend[2];
                out_item_next.out_green = blend[1];
                out_item_next.out_blue  = blend[0];
            end
            mscg_pkg::ST_LAST:
            begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    // ---- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mscg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- datapath registers
    always_ff @(posedge clk)
    begin
        if (lookup_accept)
        begin
            k_reg     <= in_item.entry_index;
            plast_reg <= p_last[mscg_pkg::SLOT_W-1:0];
        end
        if ((state_reg == mscg_pkg::ST_SPAN) && div_res[0].done)
        begin
            den_reg <= span - 1'b1;
        end
        if (state_reg == mscg_pkg::ST_SEG)
        begin
            seg_reg <= seg_q[mscg_pkg::SLOT_W-1:0];
            pos_reg <= div_res[0].remainder[mscg_pkg::IDX_W-1:0];
        end
        if (state_reg == mscg_pkg::ST_RDA)
        begin
            a_reg <= ram_rd_data;
        end
        if (state_reg == mscg_pkg::ST_RDB)
        begin
            for (int i = 0; i < mscg_pkg::NUM_COMP; i++)
            begin
                neg_reg[i] <= (ram_rd_data[i] < a_reg[i]);
                mag_reg[i] <= (ram_rd_data[i] < a_reg[i]) ? a_reg[i] - ram_rd_data[i]
                                                           : ram_rd_data[i] - a_reg[i];
            end
        end
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ---- pivot memory
    mscg_ram #(
        .WIDTH (mscg_pkg::RGB_W),
        .DEPTH (mscg_pkg::MAX_PIVOTS)
    ) u_pivot_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (in_item.pivot_slot),
        .wr_data (ram_wr_data),
        .re      (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ---- divider lanes, lane 0 also does span and segment
    for (genvar g = 0; g < mscg_pkg::NUM_COMP; g++)
    begin : g_div
        mscg_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .req   (div_req[g]),
            .res   (div_res[g])
        );
    end

    // ---- assertions
    `MSCG_ASSERT(a_done_in_wait, clk, rst_n, div_res[0].done, (state_reg == mscg_pkg::ST_SPAN) || (state_reg == mscg_pkg::ST_SEG) || (state_reg == mscg_pkg::ST_DIV))
    `MSCG_ASSERT(a_lanes_lockstep, clk, rst_n, (state_reg == mscg_pkg::ST_DIV) && div_res[0].done, div_res[1].done && div_res[2].done)
    `MSCG_ASSERT_NEXT(a_busy_after_lookup, clk, rst_n, lookup_accept, !in_ready)
    `MSCG_ASSERT(a_seg_in_range, clk, rst_n, state_reg == mscg_pkg::ST_RDA, seg_reg < plast_reg)

endmodule
